### hw/rtl/cbs_pkg.sv
`default_nettype none

package cbs_pkg;

   // Datapath widths
   localparam int COUNT_WIDTH = 16;
   localparam int FRAC_BITS   = 16;
   localparam int POS_WIDTH   = 16;
   localparam int SUM_WIDTH   = 32;
   localparam int SYM_WIDTH   = 8;
   localparam int LEN_WIDTH   = 16;
   localparam int CSR_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   // Divider sizing: mag <= total, so the quotient needs FRAC_BITS + 1 bits
   localparam int TOTAL_WIDTH = COUNT_WIDTH + 1;
   localparam int REM_WIDTH   = COUNT_WIDTH + 2;
   localparam int QUOT_WIDTH  = FRAC_BITS + 1;
   localparam int STEP_WIDTH  = $clog2(FRAC_BITS + 1);

   // Sum arithmetic runs two bits wider so saturation can be detected
   localparam int ACC_WIDTH = SUM_WIDTH + 2;

   // Count saturation limit
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Running sum limits
   localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   // Symbol codes
   localparam logic [SYM_WIDTH-1:0] SYM_G = 8'd71;
   localparam logic [SYM_WIDTH-1:0] SYM_C = 8'd67;
   localparam logic [SYM_WIDTH-1:0] SYM_A = 8'd65;
   localparam logic [SYM_WIDTH-1:0] SYM_T = 8'd84;

   // Register reset values
   localparam logic [SYM_WIDTH-1:0] FIRST_SYMBOL_RESET  = SYM_G;
   localparam logic [SYM_WIDTH-1:0] SECOND_SYMBOL_RESET = SYM_C;
   localparam logic [LEN_WIDTH-1:0] CHUNK_LEN_RESET     = 16'd1000;

   // Register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FIRST_SYMBOL  = 2'd0,
      CSR_SECOND_SYMBOL = 2'd1,
      CSR_CHUNK_LEN     = 2'd2
   } cbs_csr_index_type;

endpackage

`default_nettype wire

### hw/rtl/cumulative_base_skew.sv
// Timing: a request that does not close a chunk is absorbed without a stall and gives no result.
// A request that closes a chunk (chunk_len reached or last) gives its result after the states
// START, DIVIDE and EMIT, with the bit-serial divider producing one quotient bit a cycle.
// Throughput: 1 request per cycle within a chunk; req_stall holds until a closing result loads.
// Reset (synchronous, active high): counts, position and sum cleared, registers to G, C, 1000.
`default_nettype none

module cumulative_base_skew (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [cbs_pkg::SYM_WIDTH-1:0]    req_symbol,
   input  wire logic                             req_last,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [cbs_pkg::SUM_WIDTH-1:0]  rsp_cumulative_skew,
   output logic                                  rsp_is_final,
   // configuration
   input  wire logic                             csr_write,
   input  wire logic [cbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [cbs_pkg::CSR_WIDTH-1:0]    csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_START  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } cbs_state_type;

   cbs_state_type                       state_ff, state_in;

   logic [cbs_pkg::SYM_WIDTH-1:0]       first_symbol_ff, first_symbol_in;
   logic [cbs_pkg::SYM_WIDTH-1:0]       second_symbol_ff, second_symbol_in;
   logic [cbs_pkg::LEN_WIDTH-1:0]       chunk_len_ff, chunk_len_in;

   logic [cbs_pkg::COUNT_WIDTH-1:0]     first_count_ff, first_count_in;
   logic [cbs_pkg::COUNT_WIDTH-1:0]     second_count_ff, second_count_in;
   logic [cbs_pkg::POS_WIDTH-1:0]       position_ff, position_in;
   logic [cbs_pkg::SUM_WIDTH-1:0]       running_sum_ff, running_sum_in;

   logic                                last_ff, last_in;
   logic                                neg_ff, neg_in;
   logic                                nonzero_ff, nonzero_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [cbs_pkg::SUM_WIDTH-1:0]       rsp_skew_ff, rsp_skew_in;
   logic                                rsp_final_ff, rsp_final_in;

   logic                                accept;
   logic [cbs_pkg::LEN_WIDTH-1:0]       len_eff;
   logic [cbs_pkg::POS_WIDTH:0]         pos_next;
   logic                                close_chunk;
   logic [cbs_pkg::COUNT_WIDTH-1:0]     first_next, second_next;

   logic                                div_start;
   logic [cbs_pkg::COUNT_WIDTH-1:0]     div_mag;
   logic [cbs_pkg::TOTAL_WIDTH-1:0]     div_total;
   logic                                div_done;
   logic [cbs_pkg::QUOT_WIDTH-1:0]      div_quotient;

   logic [cbs_pkg::ACC_WIDTH-1:0]       acc_sum, acc_q, acc_res;
   logic [cbs_pkg::SUM_WIDTH-1:0]       sum_sat, sum_new;
   logic                                load_rsp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Chunk bookkeeping for the incoming base
   always_comb begin
      len_eff = (chunk_len_ff == '0) ? cbs_pkg::LEN_WIDTH'(1) : chunk_len_ff;
      pos_next = {1'b0, position_ff} + 1'b1;
      close_chunk = (pos_next >= {1'b0, len_eff}) || req_last;
      first_next  = first_count_ff;
      second_next = second_count_ff;
      if (req_symbol == first_symbol_ff) begin
         if (first_count_ff != cbs_pkg::COUNT_MAX) first_next = first_count_ff + 1'b1;
      end else if (req_symbol == second_symbol_ff) begin
         if (second_count_ff != cbs_pkg::COUNT_MAX) second_next = second_count_ff + 1'b1;
      end
   end

   // Divider operands from the closed chunk's counts
   always_comb begin
      div_total = {1'b0, first_count_ff} + {1'b0, second_count_ff};
      div_mag = (first_count_ff >= second_count_ff) ? (first_count_ff - second_count_ff)
                                                    : (second_count_ff - first_count_ff);
   end

   assign div_start = (state_ff == ST_START);

   cbs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .mag      (div_mag),
      .total    (div_total),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Signed accumulate with saturation
   always_comb begin
      acc_sum = {{2{running_sum_ff[cbs_pkg::SUM_WIDTH-1]}}, running_sum_ff};
      acc_q   = {{(cbs_pkg::ACC_WIDTH-cbs_pkg::QUOT_WIDTH){1'b0}}, div_quotient};
      acc_res = neg_ff ? (acc_sum - acc_q) : (acc_sum + acc_q);
      if (!acc_res[cbs_pkg::ACC_WIDTH-1]
          && (acc_res[cbs_pkg::ACC_WIDTH-2:cbs_pkg::SUM_WIDTH-1] != 2'b00))
         sum_sat = cbs_pkg::SUM_MAX;
      else if (acc_res[cbs_pkg::ACC_WIDTH-1]
               && (acc_res[cbs_pkg::ACC_WIDTH-2:cbs_pkg::SUM_WIDTH-1] != 2'b11))
         sum_sat = cbs_pkg::SUM_MIN;
      else
         sum_sat = acc_res[cbs_pkg::SUM_WIDTH-1:0];
      sum_new = nonzero_ff ? sum_sat : running_sum_ff;
   end

   assign load_rsp = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // Configuration writes
   always_comb begin
      first_symbol_in  = first_symbol_ff;
      second_symbol_in = second_symbol_ff;
      chunk_len_in     = chunk_len_ff;
      if (csr_write) begin
         unique case (csr_index)
            cbs_pkg::CSR_FIRST_SYMBOL:  first_symbol_in  = csr_data[cbs_pkg::SYM_WIDTH-1:0];
            cbs_pkg::CSR_SECOND_SYMBOL: second_symbol_in = csr_data[cbs_pkg::SYM_WIDTH-1:0];
            cbs_pkg::CSR_CHUNK_LEN:     chunk_len_in     = csr_data[cbs_pkg::LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      position_in     = position_ff;
      running_sum_in  = running_sum_ff;
      last_in         = last_ff;
      neg_in          = neg_ff;
      nonzero_in      = nonzero_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               first_count_in  = first_next;
               second_count_in = second_next;
               if (close_chunk) begin
                  last_in  = req_last;
                  state_in = ST_START;
               end else begin
                  position_in = pos_next[cbs_pkg::POS_WIDTH-1:0];
               end
            end
         end
         ST_START: begin
            neg_in          = (second_count_ff > first_count_ff);
            nonzero_in      = (div_total != '0);
            first_count_in  = '0;
            second_count_in = '0;
            position_in     = '0;
            state_in        = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (load_rsp) begin
               running_sum_in = last_ff ? '0 : sum_new;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result register
   always_comb begin
      rsp_skew_in  = rsp_skew_ff;
      rsp_final_in = rsp_final_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_skew_in  = sum_new;
         rsp_final_in = last_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         first_symbol_ff  <= cbs_pkg::FIRST_SYMBOL_RESET;
         second_symbol_ff <= cbs_pkg::SECOND_SYMBOL_RESET;
         chunk_len_ff     <= cbs_pkg::CHUNK_LEN_RESET;
         first_count_ff   <= '0;
         second_count_ff  <= '0;
         position_ff      <= '0;
         running_sum_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         first_symbol_ff  <= first_symbol_in;
         second_symbol_ff <= second_symbol_in;
         chunk_len_ff     <= chunk_len_in;
         first_count_ff   <= first_count_in;
         second_count_ff  <= second_count_in;
         position_ff      <= position_in;
         running_sum_ff   <= running_sum_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      last_ff      <= last_in;
      neg_ff       <= neg_in;
      nonzero_ff   <= nonzero_in;
      rsp_skew_ff  <= rsp_skew_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cumulative_skew = rsp_skew_ff;
   assign rsp_is_final        = rsp_final_ff;

endmodule

`default_nettype wire

### hw/rtl/cbs_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle: floor(mag * 2^FRAC_BITS / total).
// Requires mag <= total and total != 0.
module cbs_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [cbs_pkg::COUNT_WIDTH-1:0] mag,
   input  wire logic [cbs_pkg::TOTAL_WIDTH-1:0] total,
   output logic                                done,
   output logic [cbs_pkg::QUOT_WIDTH-1:0]      quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [cbs_pkg::STEP_WIDTH-1:0]    step_ff, step_in;
   logic [cbs_pkg::REM_WIDTH-1:0]     rem_ff, rem_in;
   logic [cbs_pkg::TOTAL_WIDTH-1:0]   total_ff, total_in;
   logic [cbs_pkg::QUOT_WIDTH-1:0]    quot_ff, quot_in;

   logic [cbs_pkg::REM_WIDTH-1:0]     trial;
   logic [cbs_pkg::REM_WIDTH-1:0]     divisor;
   logic                              fits;
   logic                              last_step;

   // Shared compare/subtract step; first step tests mag itself (integer bit)
   always_comb begin
      trial = (step_ff == '0) ? rem_ff : {rem_ff[cbs_pkg::REM_WIDTH-2:0], 1'b0};
      divisor = {1'b0, total_ff};
      fits = (trial >= divisor);
      last_step = (step_ff == cbs_pkg::STEP_WIDTH'(cbs_pkg::FRAC_BITS));
   end

   // Sequencer
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      total_in = total_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         rem_in   = {2'b00, mag};
         total_in = total;
         quot_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? (trial - divisor) : trial;
         quot_in = {quot_ff[cbs_pkg::QUOT_WIDTH-2:0], fits};
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff   <= rem_in;
      total_ff <= total_in;
      quot_ff  <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire
